// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define WRMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define WRMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define WRMP_ASSERT(lbl, prop, msg)
`define WRMP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/core/wrmp_pkg.sv
// ----------------------------------------------------------------------------
// wrmp_pkg
// shared constants, types and helpers of the windowed running mean block
// ----------------------------------------------------------------------------
`default_nettype none

package wrmp_pkg;

  localparam int unsigned StoreDepth = 4096;
  localparam int unsigned SampleBits = 24;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  localparam int unsigned NumCh    = 4;
  localparam int unsigned MeanW    = 32;
  localparam int unsigned MemW     = NumCh * MeanW;
  localparam int unsigned IdxOutW  = 12;
  localparam int unsigned IdxW     = 20;
  localparam int unsigned PassW    = 20;
  localparam int unsigned RecipW   = 24;
  localparam int unsigned RelW     = 24;
  localparam int unsigned SqSumW   = 64;
  localparam int unsigned MeanSumW = 48;
  localparam int unsigned ColW     = 10;
  localparam int unsigned RowW     = 9;
  localparam int unsigned EposW    = 6;
  localparam int unsigned PtsW     = 7;
  localparam int unsigned SkipW    = 8;
  localparam int unsigned ChEnW    = 3;
  localparam int unsigned NptsW    = 3 * PtsW;
  localparam int unsigned DivW     = 64;
  localparam int unsigned DvsW     = 48;
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned PdataW   = 32;

  localparam logic [PassW-1:0]  PassMax  = '1;
  localparam logic [RecipW-1:0] RecipOne = '1;
  localparam logic [RelW-1:0]   RelMax   = '1;

  // arithmetic widths of the average update
  localparam int unsigned TgtW  = SampleBits + 9;
  localparam int unsigned OldW  = MeanW + 1;
  localparam int unsigned DiffW = MeanW + 2;
  localparam int unsigned WideW = (TgtW > DiffW) ? TgtW : DiffW;
  localparam int unsigned PrdW  = DiffW + RecipW + 1;

  typedef enum logic [2:0] {
    REG_POINTS_X       = 3'd0,
    REG_POINTS_ROWS    = 3'd1,
    REG_POINTS_ENERGY  = 3'd2,
    REG_SKIP_LEFT      = 3'd3,
    REG_SKIP_RIGHT     = 3'd4,
    REG_SKIP_TOP       = 3'd5,
    REG_CHANNEL_ENABLE = 3'd6
  } cfg_reg_e;

  // configuration as the datapath sees it, point counts already clamped
  typedef struct packed {
    logic [PtsW-1:0]  px;
    logic [PtsW-1:0]  pr;
    logic [PtsW-1:0]  pe;
    logic [SkipW-1:0] skip_left;
    logic [SkipW-1:0] skip_right;
    logic [SkipW-1:0] skip_top;
    logic [ChEnW-1:0] ch_en;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic [RelW-1:0]   rel;
    logic [PassW-1:0]  pass_count;
    logic [RecipW-1:0] recip;
  } rpt_stat_t;

  function automatic logic [PtsW-1:0] clamp_pts(input logic [PtsW-1:0] v);
    logic [PtsW-1:0] r;
    if (v == '0) begin
      r = PtsW'(1);
    end else if (v > PtsW'(64)) begin
      r = PtsW'(64);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/wrmp_if.sv
// ----------------------------------------------------------------------------
// wrmp_if
// valid/ready channels for sample words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface wrmp_in_if import wrmp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic        [SampleBits-1:0] sample_c0;
  logic signed [SampleBits-1:0] sample_c1;
  logic signed [SampleBits-1:0] sample_c2;
  logic signed [SampleBits-1:0] sample_c3;
  logic                         frame_end;

  modport source (output valid, sample_c0, sample_c1, sample_c2, sample_c3, frame_end,
                  input ready);
  modport sink (input valid, sample_c0, sample_c1, sample_c2, sample_c3, frame_end,
                output ready);
endinterface

interface wrmp_out_if import wrmp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic        [IdxOutW-1:0] point_index;
  logic        [MeanW-1:0] mean_c0;
  logic signed [MeanW-1:0] mean_c1;
  logic signed [MeanW-1:0] mean_c2;
  logic signed [MeanW-1:0] mean_c3;
  logic                    is_report;
  logic        [RelW-1:0]  relative_change;
  logic        [PassW-1:0] pass_number;
  logic                    last;

  modport source (output valid, point_index, mean_c0, mean_c1, mean_c2, mean_c3, is_report,
                  relative_change, pass_number, last, input ready);
  modport sink (input valid, point_index, mean_c0, mean_c1, mean_c2, mean_c3, is_report,
                relative_change, pass_number, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wrmp_cfg.sv
// ----------------------------------------------------------------------------
// wrmp_cfg
// apb register bank for window geometry and channel enables
// ----------------------------------------------------------------------------
`default_nettype none

module wrmp_cfg import wrmp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [PaddrW-1:0] paddr_i,
  input  wire logic [PdataW-1:0] pwdata_i,
  output logic      [PdataW-1:0] prdata_o,
  output logic                   pready_o,
  output cfg_t                   cfg_o
);

  logic [PtsW-1:0]  px_q, pr_q, pe_q;
  logic [SkipW-1:0] sl_q, sr_q, st_q;
  logic [ChEnW-1:0] en_q;
  logic             wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= PtsW'(64);
      pr_q <= PtsW'(64);
      pe_q <= PtsW'(1);
      sl_q <= '0;
      sr_q <= '0;
      st_q <= '0;
      en_q <= '1;
    end else if (wr_en) begin
      unique case (paddr_i[PaddrW-1:2])
        REG_POINTS_X:       px_q <= pwdata_i[PtsW-1:0];
        REG_POINTS_ROWS:    pr_q <= pwdata_i[PtsW-1:0];
        REG_POINTS_ENERGY:  pe_q <= pwdata_i[PtsW-1:0];
        REG_SKIP_LEFT:      sl_q <= pwdata_i[SkipW-1:0];
        REG_SKIP_RIGHT:     sr_q <= pwdata_i[SkipW-1:0];
        REG_SKIP_TOP:       st_q <= pwdata_i[SkipW-1:0];
        REG_CHANNEL_ENABLE: en_q <= pwdata_i[ChEnW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[PaddrW-1:2])
      REG_POINTS_X:       prdata_o = PdataW'(px_q);
      REG_POINTS_ROWS:    prdata_o = PdataW'(pr_q);
      REG_POINTS_ENERGY:  prdata_o = PdataW'(pe_q);
      REG_SKIP_LEFT:      prdata_o = PdataW'(sl_q);
      REG_SKIP_RIGHT:     prdata_o = PdataW'(sr_q);
      REG_SKIP_TOP:       prdata_o = PdataW'(st_q);
      REG_CHANNEL_ENABLE: prdata_o = PdataW'(en_q);
      default:            prdata_o = '0;
    endcase
  end

  always_comb begin
    cfg_o.px         = clamp_pts(px_q);
    cfg_o.pr         = clamp_pts(pr_q);
    cfg_o.pe         = clamp_pts(pe_q);
    cfg_o.skip_left  = sl_q;
    cfg_o.skip_right = sr_q;
    cfg_o.skip_top   = st_q;
    cfg_o.ch_en      = en_q;
  end

endmodule

`default_nettype wire

// File: rtl/core/wrmp_store.sv
// ----------------------------------------------------------------------------
// wrmp_store
// four-channel average memory, one word per window point, cleared after reset
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wrmp_store import wrmp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [MemW-1:0]  rdata_o,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [MemW-1:0]  wdata_i,
  output logic                  busy_o
);

  logic [MemW-1:0]  mem_q [StoreDepth];
  logic [MemW-1:0]  rdata_q;
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(StoreDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

  `WRMP_ASSERT(a_no_access_in_clear, clr_busy_q |-> !we_i && !re_i, "store accessed while clearing")
  `WRMP_ASSERT(a_rd_wr_apart, we_i |-> !re_i, "read and write in one cycle")
  `WRMP_ASSERT(a_clear_full, $fell(clr_busy_q) |-> $past(clr_addr_q) == AddrW'(StoreDepth - 1), "clear ended early")

endmodule

`default_nettype wire

// File: rtl/core/wrmp_div.sv
// ----------------------------------------------------------------------------
// wrmp_div
// restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wrmp_div import wrmp_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 done_o,
  output logic      [DivW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvsW-1:0] rem_q, dvs_q;
  logic [DivW-1:0] quo_q;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            fits;

  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DvsW-1:0] : trial[DvsW-1:0];
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// File: rtl/core/wrmp_report.sv
// ----------------------------------------------------------------------------
// wrmp_report
// frame-end precision figure, pass counter and update reciprocal
// ----------------------------------------------------------------------------
`default_nettype none

module wrmp_report import wrmp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [MeanSumW-1:0] mean_sum_i,
  input  wire logic [SqSumW-1:0]   sq_sum_i,
  input  wire logic [NptsW-1:0]    npts_i,
  output rpt_stat_t                stat_o
);

  typedef enum logic [5:0] {
    R_IDLE  = 6'b000001,
    R_AVG   = 6'b000010,
    R_MSQ   = 6'b000100,
    R_SQRT  = 6'b001000,
    R_REL   = 6'b010000,
    R_RECIP = 6'b100000
  } rstate_e;

  rstate_e           state_q;
  logic              go_q, done_q;
  logic [PassW-1:0]  pass_q;
  logic [RecipW-1:0] recip_q;
  logic [RelW-1:0]   rel_q;
  logic [MeanSumW-1:0] avg_q;
  logic [SqSumW-1:0] sqv_q, sqr_q, sqb_q;
  logic [SqSumW-1:0] sq_trial;
  logic [DivW-1:0]   dividend, quot;
  logic [DvsW-1:0]   divisor;
  logic              div_done;
  logic [PassW:0]    pass_p1;
  logic [PassW-1:0]  pass_next;

  assign pass_p1   = {1'b0, pass_q} + (PassW + 1)'(1);
  assign pass_next = (pass_q == PassMax) ? PassMax : pass_p1[PassW-1:0];
  assign sq_trial  = sqr_q + sqb_q;

  always_comb begin
    unique case (state_q)
      R_AVG: begin
        dividend = DivW'(mean_sum_i);
        divisor  = DvsW'(npts_i);
      end
      R_MSQ: begin
        dividend = sq_sum_i;
        divisor  = DvsW'(npts_i);
      end
      R_REL: begin
        dividend = DivW'({sqr_q[31:0], 16'b0});
        divisor  = avg_q;
      end
      R_RECIP: begin
        // round(2^24 / (pass + 1))
        dividend = DivW'(25'h100_0000) + DivW'(pass_p1[PassW:1]);
        divisor  = DvsW'(pass_p1);
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  wrmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      go_q    <= 1'b0;
      done_q  <= 1'b0;
      pass_q  <= '0;
      recip_q <= RecipOne;
    end else begin
      go_q   <= 1'b0;
      done_q <= 1'b0;
      unique case (state_q)
        R_IDLE: begin
          if (start_i) begin
            go_q    <= 1'b1;
            state_q <= R_AVG;
          end
        end
        R_AVG: begin
          if (div_done) begin
            go_q    <= 1'b1;
            state_q <= R_MSQ;
          end
        end
        R_MSQ: begin
          if (div_done) begin
            state_q <= R_SQRT;
          end
        end
        R_SQRT: begin
          if (sqb_q == '0) begin
            if (avg_q == '0) begin
              pass_q  <= pass_next;
              go_q    <= 1'b1;
              state_q <= R_RECIP;
            end else begin
              go_q    <= 1'b1;
              state_q <= R_REL;
            end
          end
        end
        R_REL: begin
          if (div_done) begin
            pass_q  <= pass_next;
            go_q    <= 1'b1;
            state_q <= R_RECIP;
          end
        end
        R_RECIP: begin
          if (div_done) begin
            recip_q <= (quot > DivW'(RecipOne)) ? RecipOne : quot[RecipW-1:0];
            done_q  <= 1'b1;
            state_q <= R_IDLE;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  // datapath of the report sequence
  always_ff @(posedge clk_i) begin
    if (state_q == R_AVG && div_done) begin
      avg_q <= quot[MeanSumW-1:0];
    end
    if (state_q == R_MSQ && div_done) begin
      sqv_q <= quot;
      sqr_q <= '0;
      sqb_q <= SqSumW'(1) << (SqSumW - 2);
    end
    if (state_q == R_SQRT) begin
      if (sqb_q != '0) begin
        if (sqv_q >= sq_trial) begin
          sqv_q <= sqv_q - sq_trial;
          sqr_q <= (sqr_q >> 1) + sqb_q;
        end else begin
          sqr_q <= sqr_q >> 1;
        end
        sqb_q <= sqb_q >> 2;
      end else if (avg_q == '0) begin
        // zero mean counts as tiny
        rel_q <= (sqr_q == '0) ? '0 : RelMax;
      end
    end
    if (state_q == R_REL && div_done) begin
      rel_q <= (quot > DivW'(RelMax)) ? RelMax : quot[RelW-1:0];
    end
  end

  always_comb begin
    stat_o.done       = done_q;
    stat_o.rel        = rel_q;
    stat_o.pass_count = pass_q;
    stat_o.recip      = recip_q;
  end

endmodule

`default_nettype wire

// File: rtl/core/windowed_running_mean_with_precision.sv
// ----------------------------------------------------------------------------
// windowed_running_mean_with_precision
// per-point running average of four channels over a cropped frame window,
// with a relative-change report at each frame end
// ----------------------------------------------------------------------------
// channel | dir | handshake     | word
// in_i    | in  | valid/ready   | four samples and frame_end
// out_o   | out | valid/ready   | point averages or frame-end report
// apb     | in  | psel/penable  | window geometry and channel enables
//
// a sample inside the window runs through the address, memory read, multiply,
// write-back and square states to its result; a dropped sample leaves after
// the address state. a frame end adds the report, run by the bit-serial
// divider (up to four divisions) and the 32-step square root.
// after reset the store is swept to zero, one word a cycle, over all 4096 words;
// no sample is taken in that time. a stalled output holds the block in place.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module windowed_running_mean_with_precision import wrmp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  wrmp_in_if.sink                in_i,
  wrmp_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_ADDR   = 9'b000000010,
    ST_READ   = 9'b000000100,
    ST_MUL    = 9'b000001000,
    ST_UPD    = 9'b000010000,
    ST_SQ     = 9'b000100000,
    ST_EMIT_U = 9'b001000000,
    ST_REPORT = 9'b010000000,
    ST_EMIT_R = 9'b100000000
  } state_e;

  function automatic logic signed [OldW-1:0] sat_tgt(input logic signed [WideW-1:0] v,
                                                      input logic is_c0);
    logic signed [WideW-1:0] lo, hi, r;
    hi = is_c0 ? WideW'(33'h0_FFFF_FFFF) : WideW'(33'h0_7FFF_FFFF);
    lo = is_c0 ? '0 : ~WideW'(33'h0_7FFF_FFFF);
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r[OldW-1:0];
  endfunction

  function automatic logic [MeanW-1:0] sat_new(input logic signed [PrdW-1:0] v,
                                               input logic is_c0);
    logic signed [PrdW-1:0] lo, hi, r;
    hi = is_c0 ? PrdW'(33'h0_FFFF_FFFF) : PrdW'(33'h0_7FFF_FFFF);
    lo = is_c0 ? '0 : ~PrdW'(33'h0_7FFF_FFFF);
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r[MeanW-1:0];
  endfunction

  state_e state_q, state_d;
  cfg_t   cfg;
  rpt_stat_t stat;

  logic                in_acc, upd_ok, out_free, load_u, load_r, go_d, rpt_go_q;
  logic                mem_re, mem_we, clr_busy;
  logic [MemW-1:0]     rdata, wdata;

  logic [ColW-1:0]     frame_col_q, col_inc, width;
  logic [RowW-1:0]     frame_row_q;
  logic [EposW-1:0]    epos_q, ep_at_q;
  logic [EposW:0]      epos_inc;
  logic                in_wnd, hit_q, fend_q;
  logic [EposW-1:0]    rel_row, rel_col;
  logic [12:0]         part_d, part_q;
  logic [IdxW-1:0]     idx_d, idx_q;
  logic [NptsW-1:0]    npts_q;

  logic signed [WideW-1:0] smp_q [NumCh];
  logic signed [OldW-1:0]  old_d [NumCh];
  logic signed [OldW-1:0]  old_q [NumCh];
  logic signed [OldW-1:0]  tgt_d [NumCh];
  logic signed [OldW-1:0]  tgt_q [NumCh];
  logic signed [DiffW-1:0] diff  [NumCh];
  logic signed [PrdW-1:0]  prod_d [NumCh];
  logic signed [PrdW-1:0]  prod_q [NumCh];
  logic signed [PrdW-1:0]  rnd   [NumCh];
  logic signed [PrdW-1:0]  nv_raw [NumCh];
  logic [MeanW-1:0]        new_d [NumCh];
  logic [MeanW-1:0]        new_q [NumCh];
  logic [NumCh-1:0]        ch_on;
  logic signed [DiffW-1:0] dc;
  logic [MeanW-1:0]        absdc_q;
  logic [SqSumW-1:0]       sq_q;
  logic [SqSumW-1:0]       sq_sum_q;
  logic [SqSumW:0]         sq_sum_add;
  logic [MeanSumW-1:0]     mean_sum_q;
  logic [MeanSumW:0]       mean_sum_add;
  logic                    pass_zero;
  logic [PassW-1:0]        pass_out;

  logic                    out_valid_q, o_rep_q, o_last_q;
  logic [IdxOutW-1:0]      o_idx_q;
  logic [MeanW-1:0]        o_mean_q [NumCh];
  logic [RelW-1:0]         o_rel_q;
  logic [PassW-1:0]        o_pass_q;

  wrmp_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  wrmp_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rdata),
    .we_i    (mem_we),
    .waddr_i (idx_q[AddrW-1:0]),
    .wdata_i (wdata),
    .busy_o  (clr_busy)
  );

  wrmp_report u_report (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rpt_go_q),
    .mean_sum_i (mean_sum_q),
    .sq_sum_i   (sq_sum_q),
    .npts_i     (npts_q),
    .stat_o     (stat)
  );

  assign in_i.ready = (state_q == ST_IDLE) && !clr_busy;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // window position of the incoming sample
  always_comb begin
    width   = ColW'(cfg.skip_left) + ColW'(cfg.px) + ColW'(cfg.skip_right);
    in_wnd  = (frame_row_q >= RowW'(cfg.skip_top))
           && ({1'b0, frame_row_q} < (ColW'(cfg.skip_top) + ColW'(cfg.pr)))
           && (frame_col_q >= ColW'(cfg.skip_left))
           && (frame_col_q < (ColW'(cfg.skip_left) + ColW'(cfg.px)));
    rel_row = EposW'(frame_row_q - RowW'(cfg.skip_top));
    rel_col = EposW'(frame_col_q - ColW'(cfg.skip_left));
    part_d  = 13'({7'b0, rel_row} * {6'b0, cfg.px}) + 13'(rel_col);
    epos_inc = {1'b0, epos_q} + (EposW + 1)'(1);
    col_inc  = frame_col_q + ColW'(1);
    idx_d    = IdxW'({7'b0, part_q} * {13'b0, cfg.pe}) + IdxW'(ep_at_q);
    upd_ok   = hit_q && (idx_d < IdxW'(StoreDepth));
  end

  // update arithmetic, four independent lanes
  assign ch_on     = {cfg.ch_en, 1'b1};
  assign pass_zero = (stat.pass_count == '0);
  assign pass_out  = (stat.pass_count == PassMax) ? PassMax : stat.pass_count + PassW'(1);

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      if (k == 0) begin
        old_d[k] = $signed({1'b0, rdata[MeanW-1:0]});
      end else begin
        old_d[k] = OldW'($signed(rdata[k*MeanW +: MeanW]));
      end
      tgt_d[k]  = sat_tgt(smp_q[k] <<< 8, k == 0);
      diff[k]   = DiffW'(tgt_d[k]) - DiffW'(old_d[k]);
      prod_d[k] = diff[k] * $signed({1'b0, stat.recip});
      rnd[k]    = (prod_q[k] + $signed(PrdW'(24'h80_0000))) >>> 24;
      nv_raw[k] = pass_zero ? PrdW'(tgt_q[k]) : PrdW'(old_q[k]) + rnd[k];
      new_d[k]  = ch_on[k] ? sat_new(nv_raw[k], k == 0) : '0;
    end
    wdata = {new_d[3], new_d[2], new_d[1], new_d[0]};
    dc    = $signed({2'b0, new_d[0]}) - $signed({2'b0, old_q[0][MeanW-1:0]});
    sq_sum_add   = {1'b0, sq_sum_q} + {1'b0, sq_q};
    mean_sum_add = {1'b0, mean_sum_q} + (MeanSumW + 1)'(new_q[0]);
  end

  always_comb begin
    state_d = state_q;
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    load_u  = 1'b0;
    load_r  = 1'b0;
    go_d    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        if (upd_ok) begin
          state_d = ST_READ;
        end else if (fend_q) begin
          go_d    = 1'b1;
          state_d = ST_REPORT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_UPD;
      ST_UPD: begin
        mem_we  = 1'b1;
        state_d = ST_SQ;
      end
      ST_SQ: state_d = ST_EMIT_U;
      ST_EMIT_U: begin
        if (out_free) begin
          load_u = 1'b1;
          if (fend_q) begin
            go_d    = 1'b1;
            state_d = ST_REPORT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_REPORT: begin
        if (stat.done) begin
          state_d = ST_EMIT_R;
        end
      end
      ST_EMIT_R: begin
        if (out_free) begin
          load_r  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rpt_go_q    <= 1'b0;
      frame_col_q <= '0;
      frame_row_q <= '0;
      epos_q      <= '0;
      sq_sum_q    <= '0;
      mean_sum_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rpt_go_q <= go_d;
      if (in_acc) begin
        if (in_i.frame_end) begin
          frame_col_q <= '0;
          frame_row_q <= '0;
          epos_q      <= '0;
        end else if (epos_inc >= (EposW + 1)'(cfg.pe)) begin
          epos_q <= '0;
          if (col_inc >= width) begin
            frame_col_q <= '0;
            if (frame_row_q != '1) begin
              frame_row_q <= frame_row_q + RowW'(1);
            end
          end else begin
            frame_col_q <= col_inc;
          end
        end else begin
          epos_q <= epos_inc[EposW-1:0];
        end
      end
      if (load_u) begin
        sq_sum_q   <= sq_sum_add[SqSumW] ? '1 : sq_sum_add[SqSumW-1:0];
        mean_sum_q <= mean_sum_add[MeanSumW] ? '1 : mean_sum_add[MeanSumW-1:0];
      end else if (load_r) begin
        sq_sum_q   <= '0;
        mean_sum_q <= '0;
      end
      if (load_u || load_r) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    npts_q <= NptsW'({7'b0, cfg.px} * {7'b0, cfg.pr}) * NptsW'(cfg.pe);
    if (in_acc) begin
      smp_q[0] <= $signed({{(WideW - SampleBits){1'b0}}, in_i.sample_c0});
      smp_q[1] <= WideW'(in_i.sample_c1);
      smp_q[2] <= WideW'(in_i.sample_c2);
      smp_q[3] <= WideW'(in_i.sample_c3);
      fend_q   <= in_i.frame_end;
      hit_q    <= in_wnd;
      part_q   <= part_d;
      ep_at_q  <= epos_q;
    end
    if (state_q == ST_ADDR) begin
      idx_q <= idx_d;
    end
    if (state_q == ST_MUL) begin
      old_q  <= old_d;
      tgt_q  <= tgt_d;
      prod_q <= prod_d;
    end
    if (state_q == ST_UPD) begin
      new_q   <= new_d;
      absdc_q <= dc[DiffW-1] ? MeanW'(-dc) : MeanW'(dc);
    end
    if (state_q == ST_SQ) begin
      sq_q <= {32'b0, absdc_q} * {32'b0, absdc_q};
    end
    if (load_u) begin
      o_idx_q  <= idx_q[IdxOutW-1:0];
      o_mean_q <= new_q;
      o_rep_q  <= 1'b0;
      o_rel_q  <= '0;
      o_pass_q <= pass_out;
      o_last_q <= !fend_q;
    end else if (load_r) begin
      o_idx_q  <= '0;
      for (int k = 0; k < NumCh; k++) begin
        o_mean_q[k] <= '0;
      end
      o_rep_q  <= 1'b1;
      o_rel_q  <= stat.rel;
      o_pass_q <= stat.pass_count;
      o_last_q <= 1'b1;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.point_index     = o_idx_q;
  assign out_o.mean_c0         = o_mean_q[0];
  assign out_o.mean_c1         = o_mean_q[1];
  assign out_o.mean_c2         = o_mean_q[2];
  assign out_o.mean_c3         = o_mean_q[3];
  assign out_o.is_report       = o_rep_q;
  assign out_o.relative_change = o_rel_q;
  assign out_o.pass_number     = o_pass_q;
  assign out_o.last            = o_last_q;

  `WRMP_ASSERT(a_rpt_done_waited, stat.done |-> state_q == ST_REPORT, "report finished unawaited")
  `WRMP_ASSERT(a_report_is_last, out_o.valid && out_o.is_report |-> out_o.last, "report not last")
  `WRMP_ASSERT(a_report_loaded, state_q == ST_EMIT_R && out_free |=> out_o.valid && out_o.is_report, "report word lost")
  `WRMP_ASSERT(a_go_to_report, rpt_go_q |-> state_q == ST_REPORT, "report started out of step")

endmodule

`default_nettype wire
